/* rtl/prd_pkg.sv */
// Shared types and constants for the NetPBM gray raster decoder.
// Used by every module of the decoder; depends on nothing else.
package prd_pkg;

  localparam int MAX_DIM_DEF = 4096;
  localparam int QUEUE_DEPTH = 4;
  localparam int CFG_W       = 13;
  localparam int OUT_TDATA_W = 40;

  // Configuration register indexes.
  localparam logic [1:0] REG_FORMAT_MODE  = 2'd0;
  localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd1;
  localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd2;

  // Raster kinds.
  localparam logic [2:0] FMT_ASCII_BITS = 3'd1;
  localparam logic [2:0] FMT_ASCII_GRAY = 3'd2;
  localparam logic [2:0] FMT_ASCII_RGB  = 3'd3;
  localparam logic [2:0] FMT_PACK_BITS  = 3'd4;
  localparam logic [2:0] FMT_GRAY_BYTES = 3'd5;
  localparam logic [2:0] FMT_RGB_BYTES  = 3'd6;
  localparam logic [2:0] FMT_RESET      = FMT_GRAY_BYTES;

  localparam logic [9:0]  DEC_MAX    = 10'd1023;
  localparam logic [7:0]  PIX_WHITE  = 8'd255;
  localparam logic [7:0]  PIX_BLACK  = 8'd0;
  // x / 3 == (x * 2731) >> 13 for every x below 4096.
  localparam logic [11:0] DIV3_RECIP = 12'd2731;
  localparam int          DIV3_SHIFT = 13;

  typedef enum logic [1:0] {
    CMD_PIXEL,
    CMD_BITS,
    CMD_ERROR
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e  kind;
    logic [7:0] data;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_head_t;

endpackage

/* rtl/prd_front.sv */
// Front end of the decoder: takes raster bytes, parses ASCII numbers and
// channel triples, and queues pixel, bit-group and error commands. Uses prd_pkg.
module prd_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              restart_i,
  input  logic [2:0]        fmt_i,
  input  logic              in_valid_i,
  input  logic [7:0]        in_byte_i,
  output logic              in_ready_o,
  input  logic              full_i,
  output logic              push_o,
  output prd_pkg::cmd_t     push_cmd_o
);

  logic [9:0]  acc_q, acc_d;
  logic        in_num_q, in_num_d;
  logic [1:0]  ch_idx_q, ch_idx_d;
  logic [11:0] ch_sum_q, ch_sum_d;
  logic        err_q, err_d;

  logic        accept;
  logic        is_digit;
  logic        is_ws;
  logic        is_ws_p1;
  logic [13:0] dec_next;
  logic [9:0]  dec_sat;
  logic [9:0]  tri_in;
  logic [11:0] tri_sum;
  logic [23:0] mean_prod;
  logic [7:0]  mean;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && !full_i;

  assign is_digit = in_byte_i inside {[8'h30:8'h39]};
  assign is_ws    = in_byte_i inside {8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
  assign is_ws_p1 = in_byte_i inside {8'h20, 8'h09, 8'h0A, 8'h0D};

  assign dec_next = 14'(acc_q) * 14'd10 + 14'(in_byte_i - 8'h30);
  assign dec_sat  = (dec_next > 14'(prd_pkg::DEC_MAX)) ? prd_pkg::DEC_MAX : dec_next[9:0];

  assign tri_in    = (fmt_i == prd_pkg::FMT_RGB_BYTES) ? {2'b00, in_byte_i} : acc_q;
  assign tri_sum   = ch_sum_q + 12'(tri_in);
  assign mean_prod = 24'(tri_sum) * 24'(prd_pkg::DIV3_RECIP);
  assign mean      = mean_prod[prd_pkg::DIV3_SHIFT +: 8];

  always_comb begin
    acc_d      = acc_q;
    in_num_d   = in_num_q;
    ch_idx_d   = ch_idx_q;
    ch_sum_d   = ch_sum_q;
    err_d      = err_q;
    push_o     = 1'b0;
    push_cmd_o = '{kind: prd_pkg::CMD_PIXEL, data: in_byte_i};

    if (accept && !err_q) begin
      case (fmt_i)
        prd_pkg::FMT_ASCII_BITS: begin
          if (in_byte_i == 8'h30 || in_byte_i == 8'h31) begin
            push_o     = 1'b1;
            push_cmd_o = '{kind: prd_pkg::CMD_PIXEL, data: {7'b0, in_byte_i[0]}};
          end else if (!is_ws_p1) begin
            push_o     = 1'b1;
            push_cmd_o = '{kind: prd_pkg::CMD_ERROR, data: prd_pkg::PIX_BLACK};
            err_d      = 1'b1;
          end
        end
        prd_pkg::FMT_ASCII_GRAY, prd_pkg::FMT_ASCII_RGB: begin
          if (is_digit) begin
            acc_d    = dec_sat;
            in_num_d = 1'b1;
          end else if (is_ws) begin
            if (in_num_q) begin
              acc_d    = '0;
              in_num_d = 1'b0;
              if (fmt_i == prd_pkg::FMT_ASCII_GRAY) begin
                push_o     = 1'b1;
                push_cmd_o = '{kind: prd_pkg::CMD_PIXEL, data: acc_q[7:0]};
              end else if (ch_idx_q == 2'd2) begin
                push_o     = 1'b1;
                push_cmd_o = '{kind: prd_pkg::CMD_PIXEL, data: mean};
                ch_idx_d   = '0;
                ch_sum_d   = '0;
              end else begin
                ch_idx_d = ch_idx_q + 2'd1;
                ch_sum_d = tri_sum;
              end
            end
          end else begin
            push_o     = 1'b1;
            push_cmd_o = '{kind: prd_pkg::CMD_ERROR, data: prd_pkg::PIX_BLACK};
            err_d      = 1'b1;
          end
        end
        prd_pkg::FMT_PACK_BITS: begin
          push_o     = 1'b1;
          push_cmd_o = '{kind: prd_pkg::CMD_BITS, data: in_byte_i};
        end
        prd_pkg::FMT_GRAY_BYTES: begin
          push_o     = 1'b1;
          push_cmd_o = '{kind: prd_pkg::CMD_PIXEL, data: in_byte_i};
        end
        prd_pkg::FMT_RGB_BYTES: begin
          if (ch_idx_q == 2'd2) begin
            push_o     = 1'b1;
            push_cmd_o = '{kind: prd_pkg::CMD_PIXEL, data: mean};
            ch_idx_d   = '0;
            ch_sum_d   = '0;
          end else begin
            ch_idx_d = ch_idx_q + 2'd1;
            ch_sum_d = tri_sum;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q    <= '0;
      in_num_q <= 1'b0;
      ch_idx_q <= '0;
      ch_sum_q <= '0;
      err_q    <= 1'b0;
    end else if (restart_i) begin
      acc_q    <= '0;
      in_num_q <= 1'b0;
      ch_idx_q <= '0;
      ch_sum_q <= '0;
      err_q    <= 1'b0;
    end else begin
      acc_q    <= acc_d;
      in_num_q <= in_num_d;
      ch_idx_q <= ch_idx_d;
      ch_sum_q <= ch_sum_d;
      err_q    <= err_d;
    end
  end

endmodule

/* rtl/prd_queue.sv */
// Short command queue between the front and back ends of the decoder.
// Holds prd_pkg::cmd_t entries; depends on prd_pkg.
module prd_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              flush_i,
  input  logic              push_i,
  input  prd_pkg::cmd_t     push_cmd_i,
  output logic              full_o,
  input  logic              pop_i,
  output prd_pkg::q_head_t  head_o
);

  localparam int DEPTH = prd_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);

  prd_pkg::cmd_t    mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [PTR_W:0]   count_q, count_d;
  logic             do_push, do_pop;

  assign full_o       = (count_q == (PTR_W+1)'(DEPTH));
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && (count_q != '0);
  assign head_o.valid = (count_q != '0);
  assign head_o.cmd   = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else if (flush_i) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      count_q <= count_d;
    end
  end

endmodule

/* rtl/prd_back.sv */
// Back end of the decoder: walks the image position, expands bit groups into
// pixels and drives the registered output stage. Depends on prd_pkg.
module prd_back #(
  parameter int MAX_DIM = prd_pkg::MAX_DIM_DEF,
  localparam int CNT_W  = $clog2(MAX_DIM)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           restart_i,
  input  logic [CNT_W-1:0]               w_last_i,
  input  logic [CNT_W-1:0]               h_last_i,
  input  prd_pkg::q_head_t               head_i,
  output logic                           pop_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [prd_pkg::OUT_TDATA_W-1:0] out_data_o,
  output logic                           out_last_o,
  output logic                           out_err_o
);

  logic [CNT_W-1:0] col_q, col_d;
  logic [CNT_W-1:0] row_q, row_d;
  logic [2:0]       bit_q, bit_d;
  logic             fin_q, fin_d;
  logic             ov_q, ov_d;

  logic [7:0]       pix_q, pix_d;
  logic [11:0]      ocol_q, orow_q;
  logic             done_q, done_d;
  logic             last_q, last_d;
  logic             err_q, err_d;

  logic             can_emit;
  logic             load;
  logic             col_end;
  logic             is_err;
  logic             is_bits;
  logic             item_last;
  logic [CNT_W+11:0] col_ext, row_ext;

  assign can_emit = !ov_q || out_ready_i;
  assign col_end  = (col_q == w_last_i);
  assign is_err   = (head_i.cmd.kind == prd_pkg::CMD_ERROR);
  assign is_bits  = (head_i.cmd.kind == prd_pkg::CMD_BITS);
  assign item_last = is_bits ? ((bit_q == 3'd7) || col_end) : 1'b1;
  assign col_ext  = {12'b0, col_q};
  assign row_ext  = {12'b0, row_q};

  always_comb begin
    case (head_i.cmd.kind)
      prd_pkg::CMD_PIXEL: pix_d = head_i.cmd.data;
      prd_pkg::CMD_BITS:  pix_d = head_i.cmd.data[~bit_q] ? prd_pkg::PIX_BLACK
                                                         : prd_pkg::PIX_WHITE;
      prd_pkg::CMD_ERROR: pix_d = prd_pkg::PIX_BLACK;
      default:            pix_d = prd_pkg::PIX_BLACK;
    endcase
  end

  always_comb begin
    col_d  = col_q;
    row_d  = row_q;
    bit_d  = bit_q;
    fin_d  = fin_q;
    pop_o  = 1'b0;
    load   = 1'b0;
    done_d = !is_err && col_end && (row_q == '0);
    last_d = item_last;
    err_d  = is_err;

    if (head_i.valid) begin
      if (fin_q) begin
        // The image is complete: commands are dropped until a restart.
        pop_o = 1'b1;
        bit_d = '0;
      end else if (can_emit) begin
        load = 1'b1;
        if (item_last) begin
          pop_o = 1'b1;
          bit_d = '0;
        end else begin
          bit_d = bit_q + 3'd1;
        end
        if (!is_err) begin
          if (col_end) begin
            col_d = '0;
            if (row_q == '0) begin
              fin_d = 1'b1;
            end else begin
              row_d = row_q - 1'b1;
            end
          end else begin
            col_d = col_q + 1'b1;
          end
        end
      end
    end

    if (load) begin
      ov_d = 1'b1;
    end else if (out_ready_i) begin
      ov_d = 1'b0;
    end else begin
      ov_d = ov_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      pix_q  <= pix_d;
      ocol_q <= col_ext[11:0];
      orow_q <= row_ext[11:0];
      done_q <= done_d;
      last_q <= last_d;
      err_q  <= err_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      bit_q <= '0;
      fin_q <= 1'b0;
      ov_q  <= 1'b0;
    end else if (restart_i) begin
      col_q <= '0;
      row_q <= h_last_i;
      bit_q <= '0;
      fin_q <= 1'b0;
      ov_q  <= 1'b0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      bit_q <= bit_d;
      fin_q <= fin_d;
      ov_q  <= ov_d;
    end
  end

  assign out_valid_o = ov_q;
  assign out_data_o  = {7'b0, done_q, orow_q, ocol_q, pix_q};
  assign out_last_o  = last_q;
  assign out_err_o   = err_q;

endmodule

/* rtl/pnm_raster_gray_decoder.sv */
// Top level of the NetPBM gray raster decoder: configuration registers and
// the front end, command queue and back end. Depends on prd_pkg and prd_*.

// Feed the raster bytes that follow a NetPBM header, one byte per beat, after
// writing format_mode, image_width and image_height; each register write
// restarts the image. The block takes one byte per cycle while the command
// queue has room and gives one pixel beat per cycle while m_axis_tready is
// high. A P4 byte expands to up to eight beats, one per cycle while the output
// is not stalled, from the output stage; in that mode the input keeps flowing
// only until the four-entry command queue between the parser and the pixel
// stage is full. P3 and P6 give one beat per three values. A bad character
// in P1..P3 gives one error beat and the block then drops bytes, as it does
// after the last pixel, until the next register write.
module pnm_raster_gray_decoder #(
  parameter int MAX_DIM = prd_pkg::MAX_DIM_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [1:0]                      cfg_index_i,
  input  logic [prd_pkg::CFG_W-1:0]       cfg_wdata_i,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [7:0]                      s_axis_tdata,   // [7:0] raster_byte
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [7:0] pixel_value, [19:8] column, [31:20] row, [32] image_done, rest zero
  output logic [prd_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                            m_axis_tlast,   // last_of_run
  output logic                            m_axis_tuser    // [0] error_code
);

  localparam int CNT_W = $clog2(MAX_DIM);
  localparam int DIM_W = $clog2(MAX_DIM + 1);
  localparam int EW    = (DIM_W > prd_pkg::CFG_W) ? DIM_W : prd_pkg::CFG_W;

  function automatic logic [CNT_W-1:0] dim_last(input logic [prd_pkg::CFG_W-1:0] v);
    logic [EW-1:0] e;
    begin
      e = EW'(v);
      if (e == '0) begin
        e = EW'(1);
      end else if (e > EW'(MAX_DIM)) begin
        e = EW'(MAX_DIM);
      end
      return CNT_W'(e - EW'(1));
    end
  endfunction

  logic [2:0]       mode_q, mode_d;
  logic [CNT_W-1:0] w_last_q, w_last_d;
  logic [CNT_W-1:0] h_last_q, h_last_d;
  logic             restart;

  logic             full;
  logic             push;
  prd_pkg::cmd_t    push_cmd;
  logic             pop;
  prd_pkg::q_head_t head;

  always_comb begin
    mode_d   = mode_q;
    w_last_d = w_last_q;
    h_last_d = h_last_q;
    restart  = 1'b0;
    if (cfg_we_i) begin
      case (cfg_index_i)
        prd_pkg::REG_FORMAT_MODE: begin
          mode_d  = cfg_wdata_i[2:0];
          restart = 1'b1;
        end
        prd_pkg::REG_IMAGE_WIDTH: begin
          w_last_d = dim_last(cfg_wdata_i);
          restart  = 1'b1;
        end
        prd_pkg::REG_IMAGE_HEIGHT: begin
          h_last_d = dim_last(cfg_wdata_i);
          restart  = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= prd_pkg::FMT_RESET;
      w_last_q <= '0;
      h_last_q <= '0;
    end else begin
      mode_q   <= mode_d;
      w_last_q <= w_last_d;
      h_last_q <= h_last_d;
    end
  end

  prd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .restart_i  (restart),
    .fmt_i      (mode_q),
    .in_valid_i (s_axis_tvalid),
    .in_byte_i  (s_axis_tdata),
    .in_ready_o (s_axis_tready),
    .full_i     (full),
    .push_o     (push),
    .push_cmd_o (push_cmd)
  );

  prd_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .flush_i    (restart),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (full),
    .pop_i      (pop),
    .head_o     (head)
  );

  prd_back #(
    .MAX_DIM (MAX_DIM)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .restart_i   (restart),
    .w_last_i    (w_last_q),
    .h_last_i    (h_last_d),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast),
    .out_err_o   (m_axis_tuser)
  );

endmodule

/* rtl/prd_checker.sv */
// Port-level checks for the NetPBM gray raster decoder, bound to its top level.
// Depends on prd_pkg and pnm_raster_gray_decoder.
module prd_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [prd_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                            m_axis_tlast,
  input logic                            m_axis_tuser
);

  // A waiting beat stays offered.
  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output beat withdrawn while stalled");

  // A waiting beat keeps its payload.
  a_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast)
      && $stable(m_axis_tuser))
    else $error("output payload changed while stalled");

  // An error beat is black, ends its run and never closes the image.
  a_error_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |->
      m_axis_tlast && !m_axis_tdata[32] && (m_axis_tdata[7:0] == prd_pkg::PIX_BLACK))
    else $error("malformed error beat");

  // The last pixel of the image is always the last result of its byte.
  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[32] |-> m_axis_tlast && (m_axis_tdata[19:8] == '0
      || m_axis_tdata[31:20] == '0))
    else $error("image end beat does not close its run");

endmodule

bind pnm_raster_gray_decoder prd_checker u_prd_checker (.*);
